FILE: src/fsed_pkg.sv
// fsed_pkg: shared types and constants for the fuzzy substring edit distance block
// no dependencies; imported by every module under src
`default_nettype none

package fsed_pkg;

  localparam int unsigned SepW  = 21;
  localparam int unsigned DistW = 7;
  localparam int unsigned OpW   = 2;
  localparam logic [SepW-1:0] SepReset = SepW'(32);

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_HAY    = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // control half of a token travelling down the cell chain
  typedef struct packed {
    logic vld;
    op_e  op;
    logic store;
    logic ovf;
  } tok_ctrl_t;

endpackage

`default_nettype wire

FILE: src/fsed_head.sv
// fsed_head: input side of the chain; separator register, needle count, top row cost
// depends on fsed_pkg
`default_nettype none

module fsed_head import fsed_pkg::*; #(
  parameter int unsigned MaxN = 64,
  parameter int unsigned CW   = 8,
  parameter int unsigned SW   = 21,
  parameter int unsigned IW   = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            in_valid_i,
  input  wire logic [OpW-1:0]  operation_i,
  input  wire logic [SepW-1:0] symbol_i,
  input  wire logic            cfg_valid_i,
  input  wire logic [SepW-1:0] cfg_word_separator_i,
  output tok_ctrl_t            ctrl_o,
  output logic [SW-1:0]        sym_o,
  output logic [IW-1:0]        idx_o,
  output logic [CW-1:0]        new_o,
  output logic [CW-1:0]        old_o
);

  logic [SepW-1:0] sep_q;
  logic [CW-1:0]   top_q, top_d;
  logic [IW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  tok_ctrl_t       ctrl_q, ctrl_d;
  logic [IW-1:0]   idx_d;
  logic [CW:0]     top_inc;
  op_e             op;

  assign op      = op_e'(operation_i);
  assign top_inc = {1'b0, top_q} + (CW+1)'(1);

  always_comb begin
    top_d        = top_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    idx_d        = count_q;
    ctrl_d.vld   = in_valid_i;
    ctrl_d.op    = op;
    ctrl_d.store = 1'b0;
    ctrl_d.ovf   = ovf_q;
    if (in_valid_i) begin
      unique case (op)
        OP_CLEAR: begin
          count_d    = '0;
          ovf_d      = 1'b0;
          top_d      = '0;
          ctrl_d.ovf = 1'b0;
        end
        OP_APPEND: begin
          top_d = '0;
          if (count_q < IW'(MaxN)) begin
            ctrl_d.store = 1'b1;
            count_d      = count_q + IW'(1);
          end else begin
            ovf_d      = 1'b1;
            ctrl_d.ovf = 1'b1;
          end
        end
        OP_HAY: begin
          if (symbol_i[SW-1:0] == sep_q[SW-1:0]) begin
            top_d = '0;
          end else begin
            top_d = top_inc[CW] ? '1 : top_inc[CW-1:0];
          end
        end
        OP_END: begin
          top_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SepReset;
      top_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      ctrl_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        sep_q <= cfg_word_separator_i;
      end
      if (en_i) begin
        top_q   <= top_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
        ctrl_q  <= ctrl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sym_o <= symbol_i[SW-1:0];
      idx_o <= idx_d;
      new_o <= top_d;
      old_o <= top_q;
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

FILE: src/fsed_cell.sv
// fsed_cell: one needle row of the cost table; holds its needle symbol and cost
// depends on fsed_pkg
`default_nettype none

module fsed_cell import fsed_pkg::*; #(
  parameter int unsigned Row = 1,
  parameter int unsigned CW  = 8,
  parameter int unsigned SW  = 21,
  parameter int unsigned IW  = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire tok_ctrl_t     ctrl_i,
  input  wire logic [SW-1:0] sym_i,
  input  wire logic [IW-1:0] idx_i,
  input  wire logic [CW-1:0] new_i,
  input  wire logic [CW-1:0] old_i,
  output tok_ctrl_t          ctrl_o,
  output logic [SW-1:0]      sym_o,
  output logic [IW-1:0]      idx_o,
  output logic [CW-1:0]      new_o,
  output logic [CW-1:0]      old_o
);

  localparam int unsigned CostMax = (1 << CW) - 1;
  localparam int unsigned RstInt  = (Row > CostMax) ? CostMax : Row;
  localparam logic [CW-1:0] RstC  = CW'(RstInt);

  logic [CW-1:0] c_q, c_d;
  logic          active_q, active_d;
  logic [SW-1:0] nsym_q;
  logic          nsym_we;
  tok_ctrl_t     ctrl_q;
  logic [CW:0]   a, b, d, m0, m1;
  logic [CW-1:0] cand, new_d, old_d;

  always_comb begin
    a    = {1'b0, c_q} + (CW+1)'(1);
    b    = {1'b0, new_i} + (CW+1)'(1);
    d    = {1'b0, old_i} + ((nsym_q == sym_i) ? (CW+1)'(0) : (CW+1)'(1));
    m0   = (a < b) ? a : b;
    m1   = (m0 < d) ? m0 : d;
    cand = m1[CW] ? '1 : m1[CW-1:0];
  end

  always_comb begin
    c_d      = c_q;
    active_d = active_q;
    nsym_we  = 1'b0;
    new_d    = new_i;
    old_d    = old_i;
    if (ctrl_i.vld) begin
      unique case (ctrl_i.op)
        OP_HAY: begin
          if (active_q) begin
            c_d   = cand;
            new_d = cand;
            old_d = c_q;
          end
        end
        OP_CLEAR: begin
          c_d      = RstC;
          active_d = 1'b0;
        end
        OP_APPEND: begin
          c_d = RstC;
          if (ctrl_i.store && idx_i == IW'(Row - 1)) begin
            active_d = 1'b1;
            nsym_we  = 1'b1;
          end
        end
        OP_END: begin
          c_d = RstC;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q      <= RstC;
      active_q <= 1'b0;
      ctrl_q   <= '0;
    end else if (en_i) begin
      c_q      <= c_d;
      active_q <= active_d;
      ctrl_q   <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (nsym_we) begin
        nsym_q <= sym_i;
      end
      sym_o <= sym_i;
      idx_o <= idx_i;
      new_o <= new_d;
      old_o <= old_d;
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

FILE: src/fsed_tail.sv
// fsed_tail: end of the chain; tracks the least bottom-row cost and holds the result
// depends on fsed_pkg
`default_nettype none

module fsed_tail import fsed_pkg::*; #(
  parameter int unsigned CW = 8,
  parameter int unsigned IW = 7
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tok_ctrl_t      ctrl_i,
  input  wire logic [IW-1:0]  idx_i,
  input  wire logic [CW-1:0]  new_i,
  output logic                en_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [DistW-1:0]    distance_o,
  output logic                needle_overflow_o
);

  localparam int unsigned MW = (IW > CW) ? IW : CW;

  logic [CW-1:0]    best_q, best_d;
  logic             out_valid_q, out_valid_d;
  logic             emit;
  logic [MW-1:0]    cnt_w, best_w, res;
  logic [DistW-1:0] dist_q;
  logic             ovf_q;

  assign emit  = ctrl_i.vld && ctrl_i.op == OP_END;
  // hold the chain only while an end transfer meets a result not yet taken
  assign en_o  = !(emit && out_valid_q && !out_ready_i);
  assign cnt_w  = MW'(idx_i);
  assign best_w = MW'(best_q);
  assign res    = (cnt_w < best_w) ? cnt_w : best_w;

  always_comb begin
    best_d      = best_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.vld && en_o) begin
      unique case (ctrl_i.op)
        OP_HAY: begin
          if (new_i < best_q) begin
            best_d = new_i;
          end
        end
        OP_CLEAR, OP_APPEND: begin
          best_d = '1;
        end
        OP_END: begin
          best_d      = '1;
          out_valid_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && en_o) begin
      dist_q <= res[DistW-1:0];
      ovf_q  <= ctrl_i.ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign distance_o        = dist_q;
  assign needle_overflow_o = ovf_q;

endmodule

`default_nettype wire

FILE: src/fuzzy_substring_edit_distance_top.sv
// fuzzy_substring_edit_distance_top: head, chain of MAX_NEEDLE row cells, tail
// depends on fsed_pkg, fsed_head, fsed_cell, fsed_tail
//
// Least edit distance of a loaded needle against any haystack substring that
// starts at a word start. Every transfer (clear, append, haystack symbol, end)
// enters the chain as a token and moves one cell per cycle unless the chain is
// held, so one item is taken in each cycle it is not held; the result of an
// end transfer is registered in the tail once its token has passed the head
// and every cell. Input is held back only while an end token reaches the tail
// and the previous result waits; the separator register is writable any cycle.
`default_nettype none

module fuzzy_substring_edit_distance_top import fsed_pkg::*; #(
  parameter int unsigned MAX_NEEDLE   = 64,
  parameter int unsigned COST_WIDTH   = 8,
  parameter int unsigned SYMBOL_WIDTH = 21
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [OpW-1:0]   operation_i,
  input  wire logic [SepW-1:0]  symbol_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [DistW-1:0]      distance_o,
  output logic                  needle_overflow_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [SepW-1:0]  cfg_word_separator_i
);

  localparam int unsigned SW = (SYMBOL_WIDTH < SepW) ? SYMBOL_WIDTH : SepW;
  localparam int unsigned IW = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned CW = COST_WIDTH;

  logic          en;
  tok_ctrl_t     st_ctrl [MAX_NEEDLE+1];
  logic [SW-1:0] st_sym  [MAX_NEEDLE+1];
  logic [IW-1:0] st_idx  [MAX_NEEDLE+1];
  logic [CW-1:0] st_new  [MAX_NEEDLE+1];
  logic [CW-1:0] st_old  [MAX_NEEDLE+1];

  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  fsed_head #(
    .MaxN (MAX_NEEDLE),
    .CW   (CW),
    .SW   (SW),
    .IW   (IW)
  ) u_head (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .en_i                 (en),
    .in_valid_i           (in_valid_i),
    .operation_i          (operation_i),
    .symbol_i             (symbol_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_word_separator_i (cfg_word_separator_i),
    .ctrl_o               (st_ctrl[0]),
    .sym_o                (st_sym[0]),
    .idx_o                (st_idx[0]),
    .new_o                (st_new[0]),
    .old_o                (st_old[0])
  );

  for (genvar r = 1; r <= MAX_NEEDLE; r++) begin : g_cell
    fsed_cell #(
      .Row (r),
      .CW  (CW),
      .SW  (SW),
      .IW  (IW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (st_ctrl[r-1]),
      .sym_i  (st_sym[r-1]),
      .idx_i  (st_idx[r-1]),
      .new_i  (st_new[r-1]),
      .old_i  (st_old[r-1]),
      .ctrl_o (st_ctrl[r]),
      .sym_o  (st_sym[r]),
      .idx_o  (st_idx[r]),
      .new_o  (st_new[r]),
      .old_o  (st_old[r])
    );
  end

  fsed_tail #(
    .CW (CW),
    .IW (IW)
  ) u_tail (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (st_ctrl[MAX_NEEDLE]),
    .idx_i             (st_idx[MAX_NEEDLE]),
    .new_i             (st_new[MAX_NEEDLE]),
    .en_o              (en),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .distance_o        (distance_o),
    .needle_overflow_o (needle_overflow_o)
  );

  // last stage symbol and cost history are not needed past the chain
  logic unused_tail;
  assign unused_tail = ^{st_sym[MAX_NEEDLE], st_old[MAX_NEEDLE]};

endmodule

`default_nettype wire
